// ===== hdl/cws_pkg.sv =====
// Package for the catapult winch sequencer: mode codes, register indexes,
// reset values and the status/result structs shared by the block's modules.
// No dependencies.
package cws_pkg;

    // Mode codes
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_LOADING = 3'd1;
    localparam logic [2:0] MODE_ARMED   = 3'd2;
    localparam logic [2:0] MODE_FIRING  = 3'd3;
    localparam logic [2:0] MODE_UNWIND  = 3'd4;
    localparam logic [2:0] MODE_UNWOUND = 3'd5;

    // Configuration port
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHOOT_DELAY = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DRIVE_SPEED = 1'd1;

    localparam logic [15:0]        SHOOT_DELAY_RST = 16'd1000;
    localparam logic signed [15:0] DRIVE_SPEED_RST = 16'sd26214;  // 0.8 in Q1.15

    localparam int TIMER_BITS_DEF = 16;

    // Sequencer state other than the firing timer
    typedef struct packed {
        logic [2:0] mode;
        logic       photo_prev;
    } seq_state_t;

    // One result item
    typedef struct packed {
        logic signed [15:0] drive_level;
        logic [2:0]         mode_now;
    } result_t;

    // Configuration values as seen by the step logic
    typedef struct packed {
        logic [15:0]        shoot_delay_ms;
        logic signed [15:0] drive_speed;
    } cfg_t;

endpackage

// ===== hdl/cws_channels.sv =====
// Handshake channels of the catapult winch sequencer: input items and result items.
// Depends on nothing.
interface cws_item_if;
    logic       valid;
    logic       ready;
    logic       shoot_button;
    logic       arm_button;
    logic       unwind_button;
    logic       photo_level;
    logic [7:0] elapsed_ms;

    modport source (output valid, shoot_button, arm_button, unwind_button,
                    photo_level, elapsed_ms, input ready);
    modport sink   (input valid, shoot_button, arm_button, unwind_button,
                    photo_level, elapsed_ms, output ready);
endinterface

interface cws_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive_level;
    logic [2:0]         mode_now;

    modport source (output valid, drive_level, mode_now, input ready);
    modport sink   (input valid, drive_level, mode_now, output ready);
endinterface

// ===== hdl/cws_cfg.sv =====
// Configuration registers of the winch sequencer: firing delay and drive speed.
// Depends on cws_pkg.
module cws_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [cws_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [cws_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output cws_pkg::cfg_t                      cfg
);
    import cws_pkg::*;

    logic [15:0]        shoot_delay_reg;
    logic signed [15:0] drive_speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shoot_delay_reg <= SHOOT_DELAY_RST;
            drive_speed_reg <= DRIVE_SPEED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SHOOT_DELAY: shoot_delay_reg <= cfg_data[15:0];
                CFG_DRIVE_SPEED: drive_speed_reg <= signed'(cfg_data[15:0]);
                default: ;
            endcase
        end
    end

    assign cfg.shoot_delay_ms = shoot_delay_reg;
    assign cfg.drive_speed    = drive_speed_reg;

endmodule

// ===== hdl/cws_step.sv =====
// Next-mode, firing timer and drive logic for one control period.
// Depends on cws_pkg.
module cws_step #(
    parameter int TIMER_BITS = cws_pkg::TIMER_BITS_DEF
) (
    input  cws_pkg::seq_state_t    state,
    input  logic [TIMER_BITS-1:0]  timer,
    input  cws_pkg::cfg_t          cfg,
    input  logic                   shoot_button,
    input  logic                   arm_button,
    input  logic                   unwind_button,
    input  logic                   photo_level,
    input  logic [7:0]             elapsed_ms,
    output cws_pkg::seq_state_t    state_next,
    output logic [TIMER_BITS-1:0]  timer_next,
    output cws_pkg::result_t       result
);
    import cws_pkg::*;

    localparam int CMP_BITS = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    logic                  rise;
    logic [TIMER_BITS:0]   sum;
    logic [TIMER_BITS-1:0] timer_sat;
    logic                  timer_done;
    logic signed [16:0]    neg_speed;
    logic signed [16:0]    half_neg;
    logic [2:0]            mode_next;
    logic signed [15:0]    drive;

    assign rise = photo_level & ~state.photo_prev;

    // Saturating timer advance
    assign sum        = {1'b0, timer} + (TIMER_BITS+1)'(elapsed_ms);
    assign timer_sat  = sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : sum[TIMER_BITS-1:0];
    assign timer_done = CMP_BITS'(timer_sat) >= CMP_BITS'(cfg.shoot_delay_ms);

    // Minus half speed, rounded towards minus infinity
    assign neg_speed = -{cfg.drive_speed[15], cfg.drive_speed};
    assign half_neg  = neg_speed >>> 1;

    always_comb
    begin
        mode_next  = state.mode;
        timer_next = timer;
        drive      = '0;
        case (state.mode)
            MODE_IDLE:
            begin
                if (arm_button)
                    mode_next = MODE_LOADING;
                else if (unwind_button)
                    mode_next = MODE_UNWIND;
            end
            MODE_LOADING:
            begin
                drive = cfg.drive_speed;
                if (rise)
                    mode_next = MODE_ARMED;
                else if (!arm_button)
                    mode_next = MODE_IDLE;
            end
            MODE_ARMED:
            begin
                if (shoot_button)
                begin
                    mode_next  = MODE_FIRING;
                    timer_next = '0;
                end
                else if (unwind_button)
                    mode_next = MODE_UNWIND;
            end
            MODE_FIRING:
            begin
                if (timer_done)
                begin
                    timer_next = '0;
                    mode_next  = MODE_IDLE;
                end
                else
                begin
                    timer_next = timer_sat;
                    drive      = cfg.drive_speed;
                end
            end
            MODE_UNWIND:
            begin
                drive = half_neg[15:0];
                if (!unwind_button)
                    mode_next = MODE_IDLE;
                else if (rise)
                    mode_next = MODE_UNWOUND;
            end
            MODE_UNWOUND:
            begin
                if (arm_button)
                    mode_next = MODE_LOADING;
            end
            default:
                mode_next = MODE_IDLE;
        endcase
    end

    assign state_next.mode       = mode_next;
    assign state_next.photo_prev = photo_level;
    assign result.drive_level    = drive;
    assign result.mode_now       = mode_next;

endmodule

// ===== hdl/catapult_winch_sequencer.sv =====
// Catapult winch sequencer, top level. Depends on cws_pkg, cws_channels, cws_cfg, cws_step.
// An item is held in the input register, then its result is loaded into the result register
// and offered from there; throughput is one item per cycle while the result register is empty
// or being drained, set by the single-pass step logic between the two registers.
// Reset (rst_n, asynchronous, active low): mode idle, firing timer and photo history
// cleared, both stages empty, delay 1000 ms and drive speed 0.8.
module catapult_winch_sequencer #(
    parameter int TIMER_BITS = cws_pkg::TIMER_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    cws_item_if.sink                           item,
    cws_result_if.source                       result,
    input  logic                               cfg_we,
    input  logic [cws_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [cws_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import cws_pkg::*;

    cfg_t cfg;

    // Input register
    logic       in_valid_reg;
    logic       shoot_reg;
    logic       arm_reg;
    logic       unwind_reg;
    logic       photo_reg;
    logic [7:0] elapsed_reg;

    // Sequencer state, advanced once per item that moves into the result register
    seq_state_t            state_reg;
    seq_state_t            state_next;
    logic [TIMER_BITS-1:0] timer_reg;
    logic [TIMER_BITS-1:0] timer_next;

    // Result register
    logic    out_valid_reg;
    result_t out_reg;
    result_t out_next;

    logic advance;

    cws_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cws_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .state         (state_reg),
        .timer         (timer_reg),
        .cfg           (cfg),
        .shoot_button  (shoot_reg),
        .arm_button    (arm_reg),
        .unwind_button (unwind_reg),
        .photo_level   (photo_reg),
        .elapsed_ms    (elapsed_reg),
        .state_next    (state_next),
        .timer_next    (timer_next),
        .result        (out_next)
    );

    // The result register can take a new value when empty or being drained;
    // the input register frees up in the same cycle, so a transfer per cycle holds.
    assign advance    = !out_valid_reg || result.ready;
    assign item.ready = !in_valid_reg || advance;

    // Capture the incoming transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item.ready)
            in_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            shoot_reg   <= item.shoot_button;
            arm_reg     <= item.arm_button;
            unwind_reg  <= item.unwind_button;
            photo_reg   <= item.photo_level;
            elapsed_reg <= item.elapsed_ms;
        end
    end

    // Step the sequencer only when a held item moves forward
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode       <= MODE_IDLE;
            state_reg.photo_prev <= 1'b0;
            timer_reg            <= '0;
        end
        else if (advance && in_valid_reg)
        begin
            state_reg <= state_next;
            timer_reg <= timer_next;
        end
    end

    // Result register: load a fresh result, or drop the one just transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            out_reg <= out_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.drive_level = out_reg.drive_level;
    assign result.mode_now    = out_reg.mode_now;

endmodule

// ===== tb/catapult_winch_sequencer_test.sv =====
// Self-checking testbench for catapult_winch_sequencer: directed and random control periods
// are checked against a local model of the six-mode winch sequencer.
// Depends on cws_pkg, cws_channels and the top level catapult_winch_sequencer.
`timescale 1ns / 100ps

module catapult_winch_sequencer_test;
    import cws_pkg::*;

    localparam int TIMER_W = TIMER_BITS_DEF;

    // One control period as offered on the input channel
    typedef struct packed {
        logic       shoot;
        logic       arm;
        logic       unwind;
        logic       photo;
        logic [7:0] elapsed;
    } period_t;

    // Directed row: the period, and the result where it is obvious by inspection
    typedef struct packed {
        period_t            p;
        logic               typed;
        logic signed [15:0] drive;
        logic [2:0]         mode;
    } dir_row_t;

    localparam int DIR_ROWS = 22;

    // Reset configuration: delay 1000 ms, speed 26214, so minus half speed is -13107.
    // The walk covers every mode, every transition and each priority between
    // competing buttons, plus the photo history running on through all modes.
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{'{1'b0, 1'b0, 1'b0, 1'b0, 8'd0},   1'b1, 16'sd0,      MODE_IDLE},
        '{'{1'b0, 1'b1, 1'b0, 1'b0, 8'd0},   1'b1, 16'sd0,      MODE_LOADING},
        '{'{1'b0, 1'b1, 1'b0, 1'b0, 8'd0},   1'b1, 16'sd26214,  MODE_LOADING},
        '{'{1'b0, 1'b1, 1'b0, 1'b1, 8'd0},   1'b0, 16'sd0,      MODE_IDLE},
        '{'{1'b0, 1'b0, 1'b0, 1'b1, 8'd0},   1'b0, 16'sd0,      MODE_IDLE},
        '{'{1'b1, 1'b0, 1'b1, 1'b1, 8'd255}, 1'b0, 16'sd0,      MODE_IDLE},
        '{'{1'b0, 1'b0, 1'b0, 1'b0, 8'd255}, 1'b0, 16'sd0,      MODE_IDLE},
        '{'{1'b1, 1'b1, 1'b1, 1'b1, 8'd255}, 1'b0, 16'sd0,      MODE_IDLE},
        '{'{1'b0, 1'b0, 1'b0, 1'b0, 8'd255}, 1'b0, 16'sd0,      MODE_IDLE},
        '{'{1'b0, 1'b0, 1'b0, 1'b0, 8'd255}, 1'b1, 16'sd0,      MODE_IDLE},
        '{'{1'b0, 1'b0, 1'b1, 1'b0, 8'd0},   1'b0, 16'sd0,      MODE_IDLE},
        '{'{1'b0, 1'b0, 1'b1, 1'b1, 8'd0},   1'b1, -16'sd13107, MODE_UNWOUND},
        '{'{1'b0, 1'b0, 1'b0, 1'b1, 8'd0},   1'b0, 16'sd0,      MODE_IDLE},
        '{'{1'b0, 1'b1, 1'b0, 1'b0, 8'd0},   1'b0, 16'sd0,      MODE_IDLE},
        '{'{1'b0, 1'b0, 1'b0, 1'b0, 8'd0},   1'b0, 16'sd0,      MODE_IDLE},
        '{'{1'b0, 1'b1, 1'b1, 1'b0, 8'd0},   1'b0, 16'sd0,      MODE_IDLE},
        '{'{1'b0, 1'b0, 1'b0, 1'b1, 8'd0},   1'b0, 16'sd0,      MODE_IDLE},
        '{'{1'b0, 1'b0, 1'b1, 1'b0, 8'd0},   1'b0, 16'sd0,      MODE_IDLE},
        '{'{1'b0, 1'b0, 1'b0, 1'b1, 8'd0},   1'b0, 16'sd0,      MODE_IDLE},
        '{'{1'b1, 1'b1, 1'b1, 1'b1, 8'd255}, 1'b0, 16'sd0,      MODE_IDLE},
        '{'{1'b0, 1'b1, 1'b0, 1'b1, 8'd0},   1'b0, 16'sd0,      MODE_IDLE},
        '{'{1'b0, 1'b0, 1'b0, 1'b0, 8'd0},   1'b0, 16'sd0,      MODE_IDLE}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    cws_item_if   period_ch ();
    cws_result_if drive_ch ();

    catapult_winch_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (period_ch),
        .result    (drive_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Local copy of the sequencer: mode, firing timer, photo history, registers
    logic [2:0]         win_mode;
    logic [TIMER_W-1:0] fire_ms;
    logic               photo_last;
    logic [15:0]        delay_cfg;
    logic signed [15:0] speed_cfg;

    result_t due_results [$];   // expected drive commands, oldest first
    int      mismatches;
    bit      quiet;             // no idling on either side when set
    bit      hold_request;      // asks the receiver for one long hold-off

    // Clock: 4 ns period
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Advance the local sequencer by one control period and return its command.
    function automatic result_t wind_step(input period_t p);
        logic               rise;
        logic signed [15:0] drive;
        logic [2:0]         next;
        logic [TIMER_W:0]   sum;
        logic signed [16:0] neg;
        result_t            r;
        rise  = p.photo && !photo_last;
        drive = '0;
        next  = win_mode;
        case (win_mode)
            MODE_IDLE:
            begin
                if (p.arm)
                    next = MODE_LOADING;
                else if (p.unwind)
                    next = MODE_UNWIND;
            end
            MODE_LOADING:
            begin
                drive = speed_cfg;
                if (rise)
                    next = MODE_ARMED;
                else if (!p.arm)
                    next = MODE_IDLE;
            end
            MODE_ARMED:
            begin
                if (p.shoot)
                begin
                    next    = MODE_FIRING;
                    fire_ms = '0;
                end
                else if (p.unwind)
                    next = MODE_UNWIND;
            end
            MODE_FIRING:
            begin
                // Saturate rather than wrap
                sum     = {1'b0, fire_ms} + (TIMER_W+1)'(p.elapsed);
                fire_ms = sum[TIMER_W] ? '1 : sum[TIMER_W-1:0];
                if (fire_ms >= delay_cfg)
                begin
                    fire_ms = '0;
                    next    = MODE_IDLE;
                end
                else
                    drive = speed_cfg;
            end
            MODE_UNWIND:
            begin
                // Floor of minus half: negate in 17 bits, then arithmetic shift
                neg   = -$signed({speed_cfg[15], speed_cfg});
                drive = 16'(neg >>> 1);
                if (!p.unwind)
                    next = MODE_IDLE;
                else if (rise)
                    next = MODE_UNWOUND;
            end
            MODE_UNWOUND:
            begin
                if (p.arm)
                    next = MODE_LOADING;
            end
            default:
                next = MODE_IDLE;
        endcase
        win_mode          = next;
        photo_last        = p.photo;
        r.drive_level     = drive;
        r.mode_now        = next;
        return r;
    endfunction

    // Draw a period. Most are steered by the current mode so that the
    // sequence actually gets through loading, arming and firing; the rest
    // are plain noise.
    function automatic period_t pick_period();
        period_t p;
        p.shoot   = 1'($urandom_range(0, 1));
        p.arm     = 1'($urandom_range(0, 1));
        p.unwind  = 1'($urandom_range(0, 1));
        p.photo   = 1'($urandom_range(0, 1));
        p.elapsed = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 6) != 0)
        begin
            case (win_mode)
                MODE_IDLE:
                    p.arm = ($urandom_range(0, 2) != 0);
                MODE_LOADING:
                begin
                    p.arm   = ($urandom_range(0, 7) != 0);
                    p.photo = ($urandom_range(0, 2) == 0);
                end
                MODE_ARMED:
                begin
                    p.shoot  = ($urandom_range(0, 2) == 0);
                    p.unwind = ($urandom_range(0, 3) == 0);
                end
                MODE_UNWIND:
                begin
                    p.unwind = ($urandom_range(0, 7) != 0);
                    p.photo  = ($urandom_range(0, 2) == 0);
                end
                MODE_UNWOUND:
                    p.arm = ($urandom_range(0, 2) == 0);
                default:
                    ;
            endcase
        end
        return p;
    endfunction

    // Offer one period and hold it until the transfer happens. Called at a
    // rising edge; returns at the edge of the transfer with valid still high.
    task automatic offer(input period_t p);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            period_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        period_ch.valid         <= 1'b1;
        period_ch.shoot_button  <= p.shoot;
        period_ch.arm_button    <= p.arm;
        period_ch.unwind_button <= p.unwind;
        period_ch.photo_level   <= p.photo;
        period_ch.elapsed_ms    <= p.elapsed;
        do
            @(posedge clk);
        while (!period_ch.ready);
    endtask

    task automatic step_and_expect(input period_t p);
        offer(p);
        due_results.push_back(wind_step(p));
    endtask

    // Drop valid, wait for every outstanding command, then let the
    // two-stage pipeline run dry.
    task automatic settle();
        period_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers back to back; only while the block is idle.
    task automatic set_limits(input logic [15:0] delay, input logic signed [15:0] speed);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SHOOT_DELAY;
        cfg_data  <= delay;
        @(posedge clk);
        cfg_index <= CFG_DRIVE_SPEED;
        cfg_data  <= speed;
        @(posedge clk);
        cfg_we    <= 1'b0;
        delay_cfg  = delay;
        speed_cfg  = speed;
    endtask

    // Steer into firing, then run the timer past its ceiling: one period of
    // 1 ms followed by 255 ms periods overshoots 2^16 - 1 and must clip.
    task automatic fire_to_saturation();
        period_t p;
        while (win_mode != MODE_FIRING)
        begin
            p       = '0;
            p.arm   = 1'b1;
            p.shoot = (win_mode == MODE_ARMED);
            p.photo = !photo_last;
            step_and_expect(p);
        end
        p.elapsed = 8'd1;
        while (win_mode == MODE_FIRING)
        begin
            p.shoot  = 1'($urandom_range(0, 1));
            p.arm    = 1'($urandom_range(0, 1));
            p.unwind = 1'($urandom_range(0, 1));
            p.photo  = 1'($urandom_range(0, 1));
            step_and_expect(p);
            p.elapsed = 8'd255;
        end
    endtask

    // Compare one transferred command with the oldest expectation.
    task automatic take_result();
        result_t want;
        if (due_results.size() == 0)
        begin
            $error("unexpected result: drive_level %0d mode_now %0d",
                   drive_ch.drive_level, drive_ch.mode_now);
            mismatches++;
        end
        else
        begin
            want = due_results.pop_front();
            if (drive_ch.drive_level !== want.drive_level)
            begin
                $error("drive_level: expected %0d, got %0d",
                       want.drive_level, drive_ch.drive_level);
                mismatches++;
            end
            if (drive_ch.mode_now !== want.mode_now)
            begin
                $error("mode_now: expected %0d, got %0d", want.mode_now, drive_ch.mode_now);
                mismatches++;
            end
        end
    endtask

    // Receiver: check each transfer, stall in short random bursts, and
    // honour one long hold-off on request so the input side backs up.
    initial
    begin : receiver
        int rx_gap;
        int long_hold;
        rx_gap         = 0;
        long_hold      = 0;
        drive_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (drive_ch.valid && drive_ch.ready)
                take_result();
            if (hold_request)
            begin
                hold_request = 1'b0;
                long_hold    = 300;
            end
            if (long_hold > 0)
            begin
                long_hold--;
                drive_ch.ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                drive_ch.ready <= 1'b0;
            end
            else if (!quiet && rst_n && $urandom_range(0, 5) == 0)
            begin
                rx_gap = $urandom_range(0, 7);
                drive_ch.ready <= 1'b0;
            end
            else
                drive_ch.ready <= 1'b1;
        end
    end

    // Stimulus
    initial
    begin : stimulus
        result_t want;
        logic signed [15:0] speed;
        int pick;

        // Hold every input at a known value from time zero
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = CFG_SHOOT_DELAY;
        cfg_data                = '0;
        period_ch.valid         = 1'b0;
        period_ch.shoot_button  = 1'b0;
        period_ch.arm_button    = 1'b0;
        period_ch.unwind_button = 1'b0;
        period_ch.photo_level   = 1'b0;
        period_ch.elapsed_ms    = '0;
        mismatches              = 0;
        quiet                   = 1'b0;
        hold_request            = 1'b0;

        // Local model starts from the reset state
        win_mode   = MODE_IDLE;
        fire_ms    = '0;
        photo_last = 1'b0;
        delay_cfg  = SHOOT_DELAY_RST;
        speed_cfg  = DRIVE_SPEED_RST;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk on the reset registers; typed rows override the model
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            offer(DIR_TABLE[i].p);
            want = wind_step(DIR_TABLE[i].p);
            if (DIR_TABLE[i].typed)
            begin
                want.drive_level = DIR_TABLE[i].drive;
                want.mode_now    = DIR_TABLE[i].mode;
            end
            due_results.push_back(want);
        end
        settle();

        // Zero delay ends firing at once; most negative speed gives +16384 on unwind
        set_limits(16'd0, -16'sd32768);
        repeat (60) step_and_expect(pick_period());
        settle();

        // Longest delay with most positive speed: run the timer into saturation
        set_limits(16'hFFFF, 16'sd32767);
        fire_to_saturation();
        settle();

        // Assorted settings; hold the receiver off for a long stretch mid-way
        for (int ph = 0; ph < 4; ph++)
        begin
            pick = $urandom_range(0, 3);
            case (pick)
                0:       speed = -16'sd1;
                1:       speed = 16'sd1;
                default: speed = 16'($urandom);
            endcase
            set_limits(16'($urandom_range(0, 2000)), speed);
            repeat (10) step_and_expect(pick_period());
            if (ph == 1)
                hold_request = 1'b1;
            repeat (20) step_and_expect(pick_period());
            settle();
        end

        // Last part: zero speed, no idling on either side
        set_limits(16'($urandom_range(0, 600)), 16'sd0);
        quiet = 1'b1;
        repeat (60) step_and_expect(pick_period());
        settle();

        if (mismatches == 0)
            $display("catapult_winch_sequencer_test: done, clean");
        else
            $display("catapult_winch_sequencer_test: done, errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("catapult_winch_sequencer_test: done, errors");
        $finish;
    end

endmodule
